### sv/lmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmsd_pkg;

    localparam int NUM_CHIPS     = 4;
    localparam int ROWS_PER_CHIP = 8;
    localparam int SHADOW_DEPTH  = NUM_CHIPS * ROWS_PER_CHIP;

    // request codes as they arrive on the input channel
    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // index of the final byte of a request, bytes counted from zero
    localparam logic [5:0] LAST_PIXEL = 6'd7;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LAST_INIT  = 6'd39;

    localparam logic [2:0] INIT_INTENSITY_FRAME = 3'd1;

    // controller to datapath
    typedef struct packed {
        logic       accept;   // input transfer this cycle
        logic       emit;     // load the output register
        logic       last;     // loaded byte is the final one of the request
        t_req       kind;     // request being emitted
        logic [5:0] cnt;      // byte index within the request
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;       // output register can take a byte this cycle
    } t_sts;

    function automatic logic [5:0] last_index(input t_req kind);
        logic [5:0] idx;
        case (kind)
            REQ_PIXEL: idx = LAST_PIXEL;
            REQ_FILL:  idx = LAST_FILL;
            REQ_INIT:  idx = LAST_INIT;
            default:   idx = '0;
        endcase
        return idx;
    endfunction

    // register address of each set-up frame
    function automatic logic [7:0] init_addr(input logic [2:0] frame);
        logic [7:0] a;
        case (frame)
            3'd0:    a = 8'h09;
            3'd1:    a = 8'h0a;
            3'd2:    a = 8'h0b;
            3'd3:    a = 8'h0c;
            default: a = 8'h0f;
        endcase
        return a;
    endfunction

    // fixed data of each set-up frame (intensity frame is overridden)
    function automatic logic [7:0] init_val(input logic [2:0] frame);
        logic [7:0] v;
        case (frame)
            3'd0:    v = 8'h00;
            3'd1:    v = 8'h03;
            3'd2:    v = 8'h07;
            3'd3:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/lmsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire [1:0]           i_req_type,
    output logic                o_in_ready,
    input  lmsd_pkg::t_sts      i_sts,
    output lmsd_pkg::t_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [5:0]        r_cnt, n_cnt;
    lmsd_pkg::t_req    r_kind, n_kind;
    logic              accept;
    logic              emit;
    logic              last;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign emit       = (r_state == S_EMIT) && i_sts.out_free;
    assign last       = (r_cnt == lmsd_pkg::last_index(r_kind));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = lmsd_pkg::t_req'(i_req_type);
                    n_cnt  = '0;
                    // unused code: nothing to send
                    if (lmsd_pkg::t_req'(i_req_type) != lmsd_pkg::REQ_NONE) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (emit) begin
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kind  <= lmsd_pkg::REQ_NONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        o_cmd.accept = accept;
        o_cmd.emit   = emit;
        o_cmd.last   = last;
        o_cmd.kind   = r_kind;
        o_cmd.cnt    = r_cnt;
    end

`ifndef SYNTH
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after final byte");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt <= lmsd_pkg::last_index(r_kind)))
        else $error("byte counter ran past end of request");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last) |=> (r_cnt == $past(r_cnt) + 6'd1) && (r_state == S_EMIT))
        else $error("byte counter skipped or stalled on emit");
`endif

endmodule

`default_nettype wire

### sv/lmsd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire  [3:0]          i_cfg_wr_data,
    input  wire  [1:0]          i_req_type,
    input  wire  [3:0]          i_pos_x,
    input  wire  [3:0]          i_pos_y,
    input  wire                 i_light,
    input  lmsd_pkg::t_cmd      i_cmd,
    output lmsd_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [7:0]          o_spi_byte,
    output logic                o_frame_end,
    output logic                o_last
);

    logic [7:0] r_shadow [lmsd_pkg::SHADOW_DEPTH];
    logic [3:0] r_intensity;
    logic [2:0] r_row;
    logic       r_light;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_fend;
    logic       r_last;

    logic [1:0] pix_chip;
    logic [4:0] pix_idx;
    logic [7:0] pix_mask;
    logic [2:0] frame;
    logic [1:0] chip;
    logic [7:0] addr_byte;
    logic [7:0] data_byte;
    logic [7:0] n_byte;

    // quadrant to chip: upper half is chips 0/1, lower half 2/3
    assign pix_chip = {~i_pos_y[3], i_pos_x[3]};
    assign pix_idx  = {pix_chip, i_pos_x[2:0]};
    assign pix_mask = 8'd1 << i_pos_y[2:0];

    assign frame = i_cmd.cnt[5:3];
    assign chip  = i_cmd.cnt[2:1];

    always_comb begin
        case (i_cmd.kind)
            lmsd_pkg::REQ_PIXEL: begin
                addr_byte = {5'd0, r_row} + 8'd1;
                data_byte = r_shadow[{chip, r_row}];
            end
            lmsd_pkg::REQ_FILL: begin
                addr_byte = {5'd0, frame} + 8'd1;
                data_byte = {8{r_light}};
            end
            lmsd_pkg::REQ_INIT: begin
                addr_byte = lmsd_pkg::init_addr(frame);
                data_byte = (frame == lmsd_pkg::INIT_INTENSITY_FRAME)
                          ? {4'd0, r_intensity} : lmsd_pkg::init_val(frame);
            end
            default: begin
                addr_byte = '0;
                data_byte = '0;
            end
        endcase
        // even bytes carry the address, odd bytes the data
        n_byte = i_cmd.cnt[0] ? data_byte : addr_byte;
    end

    // shadow store and request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lmsd_pkg::SHADOW_DEPTH; i++) begin
                r_shadow[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            case (lmsd_pkg::t_req'(i_req_type))
                lmsd_pkg::REQ_PIXEL: begin
                    if (i_light) begin
                        r_shadow[pix_idx] <= r_shadow[pix_idx] | pix_mask;
                    end else begin
                        r_shadow[pix_idx] <= r_shadow[pix_idx] & ~pix_mask;
                    end
                end
                lmsd_pkg::REQ_FILL: begin
                    for (int i = 0; i < lmsd_pkg::SHADOW_DEPTH; i++) begin
                        r_shadow[i] <= {8{i_light}};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row   <= i_pos_x[2:0];
            r_light <= i_light;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity <= 4'd3;
        end else if (i_cfg_wr_en) begin
            r_intensity <= i_cfg_wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte <= n_byte;
            r_fend <= (i_cmd.cnt[2:0] == 3'd7);
            r_last <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_spi_byte     = r_byte;
    assign o_frame_end    = r_fend;
    assign o_last         = r_last;

endmodule

`default_nettype wire

### sv/led_matrix_shadow_driver.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                   transfer when
// -------   ---------------------------------------   ------------------------
// request   i_in_valid / o_in_ready, req/pos/light    i_in_valid & o_in_ready
// byte out  o_out_valid / i_out_ready, byte/flags     o_out_valid & i_out_ready
// config    i_cfg_wr_en / i_cfg_wr_data (intensity)   i_cfg_wr_en, no wait
//
// one request at a time: after a request transfer, one byte per cycle is loaded into
// the output register while the output is not stalled, until the request's last byte
// the byte counter of the controller and the single output register set this pace
// a stalled output holds its byte and freezes the counter until the consumer takes it
// synchronous active-low reset clears the shadow store, intensity goes to 3
// the next request is taken while the final byte still waits in the output register

module led_matrix_shadow_driver (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration
    input  wire        i_cfg_wr_en,
    input  wire  [3:0] i_cfg_wr_data,
    // request channel
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [1:0] i_req_type,
    input  wire  [3:0] i_pos_x,
    input  wire  [3:0] i_pos_y,
    input  wire        i_light,
    // byte channel
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_spi_byte,
    output logic       o_frame_end,
    output logic       o_last
);

    // command from controller: accept, emit, last flag, byte index and request kind
    lmsd_pkg::t_cmd cmd;
    // status back from the datapath: output register has room
    lmsd_pkg::t_sts sts;

    // sequencer: idle / emit, counts bytes of the current request
    lmsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // shadow rows, intensity register, byte builder and output register
    lmsd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_light       (i_light),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_spi_byte    (o_spi_byte),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

### tb/led_matrix_shadow_driver_tb.sv
`timescale 1ns / 1ps

module led_matrix_shadow_driver_tb;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int SETTLE_WAIT  = 12;      // quiet cycles before a config write and at the end
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 62;      // per phase, five phases

    // set-up frames: register address and data, intensity frame takes the register
    localparam logic [7:0] SETUP_ADDR [5] = '{8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0f};
    localparam logic [7:0] SETUP_DATA [5] = '{8'h00, 8'h03, 8'h07, 8'h01, 8'h00};
    localparam logic [7:0] ROW_ALL_ON = 8'hff;

    typedef struct packed {
        lmsd_pkg::t_req kind;
        logic [3:0]     x;
        logic [3:0]     y;
        logic           on;
    } t_led_req;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       last;
    } t_spi_word;

    typedef enum logic [1:0] {
        STALL_NONE,     // always ready
        STALL_COIN,     // ready half of the time
        STALL_SPARSE,   // ready a quarter of the time
        STALL_LIGHT     // ready most of the time
    } t_stall_mode;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = '0;
    logic [3:0] pos_x = '0;
    logic [3:0] pos_y = '0;
    logic       light = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] spi_byte;
    logic       frame_end;
    logic       last;

    // request queue feeding the driver, and the bytes the chain should see
    t_led_req   pending_reqs [$];
    t_spi_word  expected_bytes [$];

    // mirror of the shadow store and the intensity register
    logic [7:0] mirror_rows [lmsd_pkg::NUM_CHIPS][lmsd_pkg::ROWS_PER_CHIP];
    logic [3:0] cur_intensity = 4'd3;

    int         queued_count = 0;
    int         accepted_count = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         byte_count = 0;

    // driver pacing
    t_led_req   cur_req;
    int         burst_left = 0;
    int         gap_left = 0;

    // receiver pacing
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_tick = 0;

    always #1 clk = ~clk;

    led_matrix_shadow_driver dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_light       (light),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_spi_byte    (spi_byte),
        .o_frame_end   (frame_end),
        .o_last        (last)
    );

    // one frame: (addr, data) for each chip, chip 0 first
    task automatic push_frame(input logic [7:0] addr,
                              input logic [7:0] vals [lmsd_pkg::NUM_CHIPS],
                              input logic final_frame);
        t_spi_word w;
        for (int c = 0; c < lmsd_pkg::NUM_CHIPS; c++) begin
            w.data      = addr;
            w.frame_end = 1'b0;
            w.last      = 1'b0;
            expected_bytes.push_back(w);
            w.data      = vals[c];
            w.frame_end = (c == lmsd_pkg::NUM_CHIPS - 1);
            w.last      = final_frame && (c == lmsd_pkg::NUM_CHIPS - 1);
            expected_bytes.push_back(w);
        end
    endtask

    // update the mirror for one accepted request and queue its byte stream
    task automatic predict_request(input t_led_req r);
        logic [7:0] vals [lmsd_pkg::NUM_CHIPS];
        logic [7:0] fill_val;
        logic [2:0] row;
        int         chip;
        case (r.kind)
            lmsd_pkg::REQ_PIXEL: begin
                row = r.x[2:0];
                // quadrant select: top half is chips 0/1, bottom half chips 2/3
                if (r.y >= 4'd8)
                    chip = (r.x >= 4'd8) ? 1 : 0;
                else
                    chip = (r.x >= 4'd8) ? 3 : 2;
                mirror_rows[chip][row][r.y[2:0]] = r.on;
                for (int c = 0; c < lmsd_pkg::NUM_CHIPS; c++)
                    vals[c] = mirror_rows[c][row];
                push_frame({5'd0, row} + 8'd1, vals, 1'b1);
            end
            lmsd_pkg::REQ_FILL: begin
                fill_val = r.on ? ROW_ALL_ON : 8'h00;
                for (int c = 0; c < lmsd_pkg::NUM_CHIPS; c++) begin
                    vals[c] = fill_val;
                    for (int k = 0; k < lmsd_pkg::ROWS_PER_CHIP; k++)
                        mirror_rows[c][k] = fill_val;
                end
                for (int k = 0; k < lmsd_pkg::ROWS_PER_CHIP; k++)
                    push_frame(8'(k + 1), vals, k == lmsd_pkg::ROWS_PER_CHIP - 1);
            end
            lmsd_pkg::REQ_INIT: begin
                for (int f = 0; f < 5; f++) begin
                    for (int c = 0; c < lmsd_pkg::NUM_CHIPS; c++)
                        vals[c] = (f == 1) ? {4'd0, cur_intensity} : SETUP_DATA[f];
                    push_frame(SETUP_ADDR[f], vals, f == 4);
                end
            end
            default: begin
                // unused request code: no bytes, no state change
            end
        endcase
    endtask

    task automatic queue_req(input lmsd_pkg::t_req kind, input logic [3:0] x,
                             input logic [3:0] y, input logic on);
        t_led_req r;
        r.kind = kind;
        r.x    = x;
        r.y    = y;
        r.on   = on;
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    // mostly pixel writes, with fills, set-up sequences and unused codes mixed in
    task automatic queue_random(input int n);
        int             made;
        int             roll;
        lmsd_pkg::t_req kind;
        made = 0;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 68)
                kind = lmsd_pkg::REQ_PIXEL;
            else if (roll < 76)
                kind = lmsd_pkg::REQ_FILL;
            else if (roll < 88)
                kind = lmsd_pkg::REQ_INIT;
            else
                kind = lmsd_pkg::REQ_NONE;
            queue_req(kind, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      $urandom_range(0, 99) < 65);
            made++;
        end
    endtask

    // block drained: every request taken, every byte seen, then a few quiet cycles
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_intensity(input logic [3:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_intensity = v;
    endtask

    task automatic report_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // request driver: bursts of transfers separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_request(cur_req);
                accepted_count++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    cur_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_req.kind;
                    pos_x    <= cur_req.x;
                    pos_y    <= cur_req.y;
                    light    <= cur_req.on;
                    burst_left--;
                    // end of burst: back-to-back bursts a third of the time
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // byte monitor and receiver stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                byte_count++;
                if (expected_bytes.size() == 0) begin
                    report_fail($sformatf("byte %0d: unexpected data=%02h fe=%b last=%b",
                                          byte_count, spi_byte, frame_end, last));
                end else begin
                    t_spi_word want;
                    want = expected_bytes.pop_front();
                    if (want.data !== spi_byte || want.frame_end !== frame_end ||
                        want.last !== last)
                        report_fail($sformatf(
                            "byte %0d: want data=%02h fe=%b last=%b got data=%02h fe=%b last=%b",
                            byte_count, want.data, want.frame_end, want.last,
                            spi_byte, frame_end, last));
                end
            end
            // step the stall tick and pick a new random stall behavior when it reaches its period
            stall_tick++;
            if (stall_tick % 48 == 0)
                stall_mode = t_stall_mode'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:   out_ready <= 1'b1;
                STALL_COIN:   out_ready <= $urandom_range(0, 1);
                STALL_SPARSE: out_ready <= (stall_tick % 4 == 0);
                default:      out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // hard stop if the block hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_matrix_shadow_driver: mismatch");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < lmsd_pkg::NUM_CHIPS; c++)
            for (int k = 0; k < lmsd_pkg::ROWS_PER_CHIP; k++)
                mirror_rows[c][k] = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset intensity, every quadrant corner, quadrant borders,
        // repeated and cleared pixels, fills both ways, unused code, ignored fields
        queue_req(lmsd_pkg::REQ_INIT,  4'd0,  4'd0,  1'b0);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd0,  4'd0,  1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd15, 4'd15, 1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd0,  4'd15, 1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd15, 4'd0,  1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd7,  4'd8,  1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd8,  4'd7,  1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd15, 4'd15, 1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd15, 4'd15, 1'b0);
        queue_req(lmsd_pkg::REQ_NONE,  4'd15, 4'd15, 1'b1);
        queue_req(lmsd_pkg::REQ_FILL,  4'd9,  4'd6,  1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd3,  4'd12, 1'b0);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd8,  4'd8,  1'b0);
        queue_req(lmsd_pkg::REQ_FILL,  4'd15, 4'd15, 1'b0);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd5,  4'd5,  1'b0);
        queue_req(lmsd_pkg::REQ_INIT,  4'd15, 4'd15, 1'b1);
        queue_req(lmsd_pkg::REQ_NONE,  4'd0,  4'd0,  1'b0);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd8,  4'd8,  1'b1);
        queue_req(lmsd_pkg::REQ_PIXEL, 4'd10, 4'd2,  1'b1);
        wait_idle();

        // random phases, each under its own intensity setting
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       write_intensity(4'd0);
                1:       write_intensity(4'd15);
                3:       write_intensity(4'd8);
                default: write_intensity(4'($urandom_range(0, 15)));
            endcase
            queue_req(lmsd_pkg::REQ_INIT, 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), $urandom_range(0, 1));
            queue_random(RANDOM_ITEMS);
            wait_idle();
        end

        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("led_matrix_shadow_driver: match");
        else
            $display("led_matrix_shadow_driver: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/lmsd_pkg.sv
sv/lmsd_ctrl.sv
sv/lmsd_dp.sv
sv/led_matrix_shadow_driver.sv
tb/led_matrix_shadow_driver_tb.sv
